/* src/hhm_pkg.sv */
// Shared types, constants and the control store for the heading-hold wheel speed block.
package hhm_pkg;

    typedef struct packed {
        logic               action;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] turn_rate_cmd;
        logic signed [15:0] yaw_angle;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] wheel_front_left;
        logic signed [15:0] wheel_rear_right;
        logic signed [15:0] wheel_rear_left;
        logic signed [15:0] wheel_front_right;
        logic signed [15:0] turn_rate_used;
    } t_out_item;

    typedef struct packed {
        logic [15:0]        prop_gain;
        logic [15:0]        integ_gain;
        logic [15:0]        deriv_gain;
        logic signed [15:0] yaw_offset;
        logic [15:0]        half_span;
        logic [15:0]        rpm_scale;
    } t_cfg;

    localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [2:0] REG_INTEG_GAIN = 3'd1;
    localparam logic [2:0] REG_DERIV_GAIN = 3'd2;
    localparam logic [2:0] REG_YAW_OFFSET = 3'd3;
    localparam logic [2:0] REG_HALF_SPAN  = 3'd4;
    localparam logic [2:0] REG_RPM_SCALE  = 3'd5;

    localparam logic [15:0] YAW_OFFSET_RST = 16'd3686;
    localparam logic [15:0] HALF_SPAN_RST  = 16'd26214;
    localparam logic [15:0] RPM_SCALE_RST  = 16'd32666;

    localparam int ERR_DEAD    = 123;
    localparam int PI_Q12      = 12868;
    localparam int TWO_PI_Q12  = 25736;
    localparam int S16_MAX     = 32767;
    localparam int S16_MIN     = -32768;

    localparam logic signed [63:0] W_DEAD_N = 64'sd104857600;
    localparam logic signed [63:0] W_BIG_N  = 64'sd10485760000;
    localparam logic signed [15:0] W_MAX    = 16'sd10240;
    localparam logic [44:0]        DIV_RECIP = 45'd2147484;
    localparam logic signed [23:0] K_1000   = 24'sd1000;
    localparam logic signed [68:0] RND_POS  = 69'sd8589934592;
    localparam logic signed [68:0] RND_NEG  = 69'sd8589934591;

    localparam logic [1:0] WC_DEAD = 2'd0;
    localparam logic [1:0] WC_BIG  = 2'd1;
    localparam logic [1:0] WC_DIV  = 2'd2;

    localparam logic [2:0] A_E     = 3'd0;
    localparam logic [2:0] A_PROD  = 3'd1;
    localparam logic [2:0] A_INTEG = 3'd2;
    localparam logic [2:0] A_DE    = 3'd3;
    localparam logic [2:0] A_RECIP = 3'd4;
    localparam logic [2:0] A_W     = 3'd5;
    localparam logic [2:0] A_V     = 3'd6;

    localparam logic [2:0] B_1000  = 3'd0;
    localparam logic [2:0] B_P     = 3'd1;
    localparam logic [2:0] B_KI    = 3'd2;
    localparam logic [2:0] B_D     = 3'd3;
    localparam logic [2:0] B_MAG   = 3'd4;
    localparam logic [2:0] B_HSPAN = 3'd5;
    localparam logic [2:0] B_RPM   = 3'd6;

    localparam logic [1:0] ACC_NONE = 2'd0;
    localparam logic [1:0] ACC_CLR  = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;
    localparam logic [1:0] ACC_ABS  = 2'd3;

    localparam logic [2:0] MISC_NONE  = 3'd0;
    localparam logic [2:0] MISC_ERR   = 3'd1;
    localparam logic [2:0] MISC_INTEG = 3'd2;
    localparam logic [2:0] MISC_CLASS = 3'd3;
    localparam logic [2:0] MISC_WDIV  = 3'd4;
    localparam logic [2:0] MISC_ROT   = 3'd5;

    localparam logic [2:0] V_NONE  = 3'd0;
    localparam logic [2:0] V_SUM_M = 3'd1;
    localparam logic [2:0] V_DIF_M = 3'd2;
    localparam logic [2:0] V_SUM_P = 3'd3;
    localparam logic [2:0] V_DIF_P = 3'd4;

    localparam logic [1:0] BR_NONE = 2'd0;
    localparam logic [1:0] BR_VEL  = 2'd1;
    localparam logic [1:0] BR_DONE = 2'd2;

    localparam logic [1:0] WHL_FL = 2'd0;
    localparam logic [1:0] WHL_RR = 2'd1;
    localparam logic [1:0] WHL_RL = 2'd2;
    localparam logic [1:0] WHL_FR = 2'd3;

    localparam logic [4:0] STEP_ROT = 5'd11;

    typedef struct packed {
        logic [2:0] a_sel;
        logic [2:0] b_sel;
        logic       mul_en;
        logic [1:0] acc_op;
        logic [2:0] misc;
        logic [2:0] v_sel;
        logic       wheel_en;
        logic [1:0] wheel_idx;
        logic [1:0] br;
        logic [4:0] target;
    } t_uop;

    localparam t_uop UOP_NOP = '0;

    function automatic t_uop uop_rom(input logic [4:0] step);
        t_uop u;
        u = UOP_NOP;
        case (step)
            5'd0: begin
                u.misc = MISC_ERR;
                u.br = BR_VEL;
                u.target = STEP_ROT;
            end
            5'd1: begin
                u.misc = MISC_INTEG;
                u.mul_en = 1'b1; u.a_sel = A_E; u.b_sel = B_1000;
            end
            5'd2: begin
                u.mul_en = 1'b1; u.a_sel = A_PROD; u.b_sel = B_P;
                u.acc_op = ACC_CLR;
            end
            5'd3: begin
                u.mul_en = 1'b1; u.a_sel = A_INTEG; u.b_sel = B_KI;
                u.acc_op = ACC_ADD;
            end
            5'd4: begin
                u.mul_en = 1'b1; u.a_sel = A_DE; u.b_sel = B_1000;
                u.acc_op = ACC_ADD;
            end
            5'd5: begin
                u.mul_en = 1'b1; u.a_sel = A_PROD; u.b_sel = B_D;
            end
            5'd6: begin
                u.mul_en = 1'b1; u.a_sel = A_PROD; u.b_sel = B_1000;
            end
            5'd7: u.acc_op = ACC_ADD;
            5'd8: u.acc_op = ACC_ABS;
            5'd9: begin
                u.misc = MISC_CLASS;
                u.mul_en = 1'b1; u.a_sel = A_RECIP; u.b_sel = B_MAG;
            end
            5'd10: u.misc = MISC_WDIV;
            5'd11: begin
                u.mul_en = 1'b1; u.a_sel = A_W; u.b_sel = B_HSPAN;
            end
            5'd12: u.misc = MISC_ROT;
            5'd13: u.v_sel = V_SUM_M;
            5'd14: begin
                u.mul_en = 1'b1; u.a_sel = A_V; u.b_sel = B_RPM;
                u.v_sel = V_DIF_M;
            end
            5'd15: begin
                u.mul_en = 1'b1; u.a_sel = A_V; u.b_sel = B_RPM;
                u.v_sel = V_SUM_P;
                u.wheel_en = 1'b1; u.wheel_idx = WHL_FL;
            end
            5'd16: begin
                u.mul_en = 1'b1; u.a_sel = A_V; u.b_sel = B_RPM;
                u.v_sel = V_DIF_P;
                u.wheel_en = 1'b1; u.wheel_idx = WHL_RR;
            end
            5'd17: begin
                u.mul_en = 1'b1; u.a_sel = A_V; u.b_sel = B_RPM;
                u.wheel_en = 1'b1; u.wheel_idx = WHL_RL;
            end
            5'd18: begin
                u.wheel_en = 1'b1; u.wheel_idx = WHL_FR;
            end
            default: u.br = BR_DONE;
        endcase
        return u;
    endfunction

endpackage

/* src/hhm_cfg.sv */
// Configuration register bank with its APB-style access port.
module hhm_cfg import hhm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain  <= '0;
            r_cfg.integ_gain <= '0;
            r_cfg.deriv_gain <= '0;
            r_cfg.yaw_offset <= YAW_OFFSET_RST;
            r_cfg.half_span  <= HALF_SPAN_RST;
            r_cfg.rpm_scale  <= RPM_SCALE_RST;
        end else if (wr_en) begin
            unique case (paddr[4:2])
                REG_PROP_GAIN:  r_cfg.prop_gain  <= pwdata[15:0];
                REG_INTEG_GAIN: r_cfg.integ_gain <= pwdata[15:0];
                REG_DERIV_GAIN: r_cfg.deriv_gain <= pwdata[15:0];
                REG_YAW_OFFSET: r_cfg.yaw_offset <= pwdata[15:0];
                REG_HALF_SPAN:  r_cfg.half_span  <= pwdata[15:0];
                REG_RPM_SCALE:  r_cfg.rpm_scale  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_PROP_GAIN:  prdata = 32'(r_cfg.prop_gain);
            REG_INTEG_GAIN: prdata = 32'(r_cfg.integ_gain);
            REG_DERIV_GAIN: prdata = 32'(r_cfg.deriv_gain);
            REG_YAW_OFFSET: prdata = 32'(r_cfg.yaw_offset);
            REG_HALF_SPAN:  prdata = 32'(r_cfg.half_span);
            REG_RPM_SCALE:  prdata = 32'(r_cfg.rpm_scale);
            default:        prdata = '0;
        endcase
    end

endmodule

/* src/hhm_seq.sv */
// Microcode sequencer: step counter, control store read-out and branch logic.
module hhm_seq import hhm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_vel_mode,
    input  logic i_out_free,
    output logic o_busy,
    output logic o_done,
    output t_uop o_uop
);

    logic       r_busy;
    logic       n_busy;
    logic [4:0] r_step;
    logic [4:0] n_step;
    t_uop       rom_uop;

    always_comb begin
        rom_uop = uop_rom(r_step);
        o_uop   = r_busy ? rom_uop : UOP_NOP;
        o_done  = r_busy && (rom_uop.br == BR_DONE) && i_out_free;
        n_busy  = r_busy;
        n_step  = r_step;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
        end else if (r_busy) begin
            unique case (rom_uop.br)
                BR_DONE: begin
                    if (i_out_free) begin
                        n_busy = 1'b0;
                    end
                end
                BR_VEL:  n_step = i_vel_mode ? rom_uop.target : r_step + 5'd1;
                default: n_step = r_step + 5'd1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
    end

    assign o_busy = r_busy;

endmodule

/* src/hhm_dp.sv */
// Datapath: shared multiplier, accumulator, heading error, PID state and wheel rounding.
module hhm_dp import hhm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_in_item  i_in,
    input  t_cfg      i_cfg,
    input  t_uop      i_uop,
    output logic      o_vel_mode,
    output t_out_item o_result
);

    t_in_item           r_item;
    logic signed [15:0] r_e;
    logic signed [15:0] r_prev;
    logic signed [31:0] r_integ;
    logic signed [16:0] r_de;
    logic signed [68:0] r_prod;
    logic signed [63:0] r_acc;
    logic               r_neg;
    logic [1:0]         r_wcls;
    logic signed [15:0] r_w;
    logic signed [32:0] r_sum;
    logic signed [32:0] r_dif;
    logic signed [32:0] r_rot;
    logic signed [33:0] r_v;
    logic signed [15:0] r_wheel [4];

    logic signed [16:0] err_raw;
    logic signed [17:0] err_wrap;
    logic signed [15:0] err_val;
    logic signed [32:0] integ_sum;
    logic signed [31:0] integ_sat;
    logic signed [16:0] xy_sum;
    logic signed [16:0] xy_dif;
    logic signed [44:0] mul_a;
    logic signed [23:0] mul_b;
    logic signed [68:0] mul_out;
    logic signed [68:0] rnd_sum;
    logic signed [34:0] rnd_q;
    logic signed [15:0] rnd_val;
    logic [15:0]        quot;
    logic signed [15:0] w_div;

    always_comb begin
        err_raw = 17'(r_item.yaw_angle) + 17'(i_cfg.yaw_offset);
        if (err_raw > -ERR_DEAD && err_raw < ERR_DEAD) begin
            err_wrap = '0;
        end else begin
            err_wrap = 18'(err_raw);
        end
        if (err_wrap >= PI_Q12) begin
            err_wrap = err_wrap - 18'(TWO_PI_Q12);
        end else if (err_wrap <= -PI_Q12) begin
            err_wrap = err_wrap + 18'(TWO_PI_Q12);
        end
        if (err_wrap > S16_MAX) begin
            err_val = 16'sh7fff;
        end else if (err_wrap < S16_MIN) begin
            err_val = 16'sh8000;
        end else begin
            err_val = err_wrap[15:0];
        end
    end

    always_comb begin
        integ_sum = 33'(r_integ) + 33'(r_e);
        if (integ_sum[32] != integ_sum[31]) begin
            integ_sat = integ_sum[32] ? 32'sh80000000 : 32'sh7fffffff;
        end else begin
            integ_sat = integ_sum[31:0];
        end
        xy_sum = 17'(r_item.vel_x) + 17'(r_item.vel_y);
        xy_dif = 17'(r_item.vel_x) - 17'(r_item.vel_y);
    end

    always_comb begin
        unique case (i_uop.a_sel)
            A_E:     mul_a = 45'(r_e);
            A_PROD:  mul_a = $signed(r_prod[44:0]);
            A_INTEG: mul_a = 45'(r_integ);
            A_DE:    mul_a = 45'(r_de);
            A_RECIP: mul_a = $signed(DIV_RECIP);
            A_W:     mul_a = 45'(r_w);
            A_V:     mul_a = 45'(r_v);
            default: mul_a = '0;
        endcase
        unique case (i_uop.b_sel)
            B_1000:  mul_b = K_1000;
            B_P:     mul_b = $signed(24'(i_cfg.prop_gain));
            B_KI:    mul_b = $signed(24'(i_cfg.integ_gain));
            B_D:     mul_b = $signed(24'(i_cfg.deriv_gain));
            B_MAG:   mul_b = $signed(24'(r_acc[35:13]));
            B_HSPAN: mul_b = $signed(24'(i_cfg.half_span));
            B_RPM:   mul_b = $signed(24'(i_cfg.rpm_scale));
            default: mul_b = '0;
        endcase
        mul_out = mul_a * mul_b;
    end

    always_comb begin
        rnd_sum = r_prod + (r_prod[68] ? RND_NEG : RND_POS);
        rnd_q   = rnd_sum[68:34];
        if (rnd_q > S16_MAX) begin
            rnd_val = 16'sh7fff;
        end else if (rnd_q < S16_MIN) begin
            rnd_val = 16'sh8000;
        end else begin
            rnd_val = rnd_q[15:0];
        end
        quot = 16'(r_prod[41:28]);
        unique case (r_wcls)
            WC_DEAD: w_div = '0;
            WC_BIG:  w_div = r_neg ? -W_MAX : W_MAX;
            default: w_div = r_neg ? -$signed(quot) : $signed(quot);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_integ <= '0;
        end else if (i_uop.misc == MISC_INTEG) begin
            r_prev  <= r_e;
            r_integ <= integ_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_in;
        end
        if (i_uop.mul_en) begin
            r_prod <= mul_out;
        end
        case (i_uop.acc_op)
            ACC_CLR: r_acc <= '0;
            ACC_ADD: r_acc <= r_acc + r_prod[63:0];
            ACC_ABS: begin
                r_acc <= r_acc[63] ? -r_acc : r_acc;
                r_neg <= r_acc[63];
            end
            default: ;
        endcase
        case (i_uop.misc)
            MISC_ERR: begin
                r_e   <= err_val;
                r_w   <= r_item.turn_rate_cmd;
                r_sum <= {xy_sum, 16'd0};
                r_dif <= {xy_dif, 16'd0};
            end
            MISC_INTEG: r_de <= 17'(r_e) - 17'(r_prev);
            MISC_CLASS: begin
                if (r_acc < W_DEAD_N) begin
                    r_wcls <= WC_DEAD;
                end else if (r_acc > W_BIG_N) begin
                    r_wcls <= WC_BIG;
                end else begin
                    r_wcls <= WC_DIV;
                end
            end
            MISC_WDIV: r_w <= w_div;
            MISC_ROT:  r_rot <= r_prod[32:0];
            default: ;
        endcase
        case (i_uop.v_sel)
            V_SUM_M: r_v <= 34'(r_sum) - 34'(r_rot);
            V_DIF_M: r_v <= 34'(r_dif) - 34'(r_rot);
            V_SUM_P: r_v <= 34'(r_sum) + 34'(r_rot);
            V_DIF_P: r_v <= 34'(r_dif) + 34'(r_rot);
            default: ;
        endcase
        if (i_uop.wheel_en) begin
            r_wheel[i_uop.wheel_idx] <= rnd_val;
        end
    end

    assign o_vel_mode = !r_item.action;
    assign o_result.wheel_front_left  = r_wheel[WHL_FL];
    assign o_result.wheel_rear_right  = r_wheel[WHL_RR];
    assign o_result.wheel_rear_left   = r_wheel[WHL_RL];
    assign o_result.wheel_front_right = r_wheel[WHL_FR];
    assign o_result.turn_rate_used    = r_w;

endmodule

/* src/heading_hold_mecanum_wheel_speeds.sv */
// Top level of the heading-hold mecanum wheel speed controller.
//
//   Channel   Direction  Transfer when                 Payload
//   input     in         i_in_valid && o_in_ready      i_in  (t_in_item)
//   output    out        o_out_valid && i_out_ready    o_out (t_out_item)
//   config    in         psel && penable && pwrite     paddr, pwdata
//
// A heading-hold item runs the whole microcode program through the one shared
// multiplier from its transfer to a registered result; a velocity-mode item
// skips the PID steps. The next item is taken once the result is in
// the output register. Synchronous reset clears the sequencer, the output
// valid flag and the loop state; no clearing pass is needed. If the output
// register is still full, the program holds at its last step until it frees.
module heading_hold_mecanum_wheel_speeds import hhm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg      cfg;
    t_uop      uop;
    t_out_item dp_result;
    logic      busy;
    logic      done;
    logic      in_xfer;
    logic      out_free;
    logic      vel_mode;
    logic      r_out_valid;
    t_out_item r_out;

    assign o_in_ready = !busy;
    assign in_xfer    = i_in_valid && !busy;
    assign out_free   = !r_out_valid || i_out_ready;

    hhm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    hhm_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_xfer),
        .i_vel_mode (vel_mode),
        .i_out_free (out_free),
        .o_busy     (busy),
        .o_done     (done),
        .o_uop      (uop)
    );

    hhm_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (in_xfer),
        .i_in       (i_in),
        .i_cfg      (cfg),
        .i_uop      (uop),
        .o_vel_mode (vel_mode),
        .o_result   (dp_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out <= dp_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
